@@ rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, constants, sequencer states and the add-reduce unit's structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int OPW           = 31;
  localparam int IN_W          = 32;
  localparam int MULT_BITS_DEF = 31;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 2;

  localparam logic [OPW-1:0] MOD_RESET = {OPW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SETUP,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OPW-1:0] modulus;
    logic [OPW-1:0] acc;
    logic [OPW-1:0] addend;
    logic           add_en;
    logic [OPW-1:0] dbl_in;
    logic           dbl_cin;
  } step_req_t;

  typedef struct packed {
    logic [OPW-1:0] acc;
    logic [OPW-1:0] dbl;
  } step_rsp_t;

endpackage

`default_nettype wire

@@ rtl/mexp_if.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation channel interfaces
// Valid/ready channels for operand transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if;
  logic                        valid;
  logic                        ready;
  logic [mexp_pkg::IN_W-1:0]   base;
  logic [mexp_pkg::IN_W-1:0]   exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::OPW-1:0]   power;

  modport source (output valid, output power, input ready);
  modport sink (input valid, input power, output ready);
endinterface

`default_nettype wire

@@ rtl/mexp_addmod.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation add-reduce unit
// Two modular lanes: a conditional accumulate and a doubling with carry-in,
// each reduced by a single compare and subtract against the modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_addmod (
  input  wire mexp_pkg::step_req_t req,
  output mexp_pkg::step_rsp_t      rsp
);

  localparam int SW = mexp_pkg::OPW + 1;

  logic [SW-1:0] mod_ext;
  logic [SW-1:0] acc_sum;
  logic [SW-1:0] dbl_sum;
  logic [SW-1:0] acc_red;
  logic [SW-1:0] dbl_red;

  always_comb begin
    mod_ext = {1'b0, req.modulus};
    acc_sum = {1'b0, req.acc} + (req.add_en ? {1'b0, req.addend} : '0);
    dbl_sum = {1'b0, req.dbl_in} + {1'b0, req.dbl_in} + {{(SW-1){1'b0}}, req.dbl_cin};
    acc_red = (acc_sum >= mod_ext) ? (acc_sum - mod_ext) : acc_sum;
    dbl_red = (dbl_sum >= mod_ext) ? (dbl_sum - mod_ext) : dbl_sum;
    rsp.acc = acc_red[mexp_pkg::OPW-1:0];
    rsp.dbl = dbl_red[mexp_pkg::OPW-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Computes base^exponent mod modulus by right-to-left square-and-multiply,
// with every modular product built by shift-and-add on one add-reduce unit.
//
//   Channel  Direction  Payload              Handshake
//   in_ch    input      base, exponent       valid/ready
//   out_ch   output     power                valid/ready
//   cfg      input      modulus (addr 0x0)   APB, pready always high
//
// Each transaction computes P modular products, where P is the number of set
// bits of the exponent plus its bit length (at most 64), and then waits for
// the output channel to take the result.
// The base is first reduced by a 32-step restoring remainder on the same unit.
// A zero modulus yields 0 with no products. The core takes a new operand only
// after the previous result has been taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core #(
  parameter int MULT_BITS = mexp_pkg::MULT_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  mexp_in_if.sink                             in_ch,
  mexp_out_if.source                          out_ch,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [mexp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire  [mexp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mexp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int OPW    = mexp_pkg::OPW;
  localparam int IN_W   = mexp_pkg::IN_W;
  localparam int MAXCNT = (MULT_BITS > IN_W) ? MULT_BITS : IN_W;
  localparam int CNT_W  = $clog2(MAXCNT + 1);

  mexp_pkg::state_t state_r, state_nxt;

  logic [OPW-1:0]       modulus_r;
  logic [IN_W-1:0]      e_r, e_nxt;
  logic [IN_W-1:0]      base_r, base_nxt;
  logic [OPW-1:0]       sq_r, sq_nxt;
  logic [OPW-1:0]       res_r, res_nxt;
  logic [MULT_BITS-1:0] x_r, x_nxt;
  logic [OPW-1:0]       acc_r, acc_nxt;
  logic [OPW-1:0]       addend_r, addend_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 sel_r, sel_nxt;

  logic                 in_fire;
  logic                 cfg_wr;
  logic                 last_step;
  logic [IN_W-1:0]      e_shift;
  logic [OPW-1:0]       x_src;

  mexp_pkg::step_req_t  step_req;
  mexp_pkg::step_rsp_t  step_rsp;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign last_step = (cnt_r == CNT_W'(1));
  assign e_shift   = e_r >> 1;
  assign pready    = 1'b1;
  assign prdata    = (paddr == '0) ? {{(mexp_pkg::CFG_DATA_W-OPW){1'b0}}, modulus_r} : '0;

  assign in_ch.ready  = (state_r == mexp_pkg::ST_IDLE);
  assign out_ch.valid = (state_r == mexp_pkg::ST_DONE);
  assign out_ch.power = res_r;

  always_comb begin
    step_req.modulus = modulus_r;
    step_req.acc     = acc_r;
    step_req.addend  = addend_r;
    step_req.add_en  = x_r[0];
    if (state_r == mexp_pkg::ST_REDUCE) begin
      step_req.dbl_in  = sq_r;
      step_req.dbl_cin = base_r[IN_W-1];
    end else begin
      step_req.dbl_in  = addend_r;
      step_req.dbl_cin = 1'b0;
    end
  end

  mexp_addmod u_addmod (
    .req (step_req),
    .rsp (step_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (modulus_r == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (last_step) begin
          state_nxt = (e_r == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_SETUP;
        end
      end
      mexp_pkg::ST_SETUP: begin
        state_nxt = mexp_pkg::ST_MUL;
      end
      mexp_pkg::ST_MUL: begin
        if (last_step) begin
          if (sel_r && (e_shift == '0)) begin
            state_nxt = mexp_pkg::ST_DONE;
          end else begin
            state_nxt = mexp_pkg::ST_SETUP;
          end
        end
      end
      mexp_pkg::ST_DONE: begin
        if (out_ch.ready) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    e_nxt      = e_r;
    base_nxt   = base_r;
    sq_nxt     = sq_r;
    res_nxt    = res_r;
    x_nxt      = x_r;
    acc_nxt    = acc_r;
    addend_nxt = addend_r;
    cnt_nxt    = cnt_r;
    sel_nxt    = sel_r;
    x_src      = sel_r ? sq_r : res_r;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_fire) begin
          e_nxt    = in_ch.exponent;
          base_nxt = in_ch.base;
          sq_nxt   = '0;
          res_nxt  = (modulus_r > OPW'(1)) ? OPW'(1) : '0;
          cnt_nxt  = CNT_W'(IN_W);
        end
      end
      mexp_pkg::ST_REDUCE: begin
        base_nxt = base_r << 1;
        sq_nxt   = step_rsp.dbl;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (last_step) begin
          sel_nxt = ~e_r[0];
        end
      end
      mexp_pkg::ST_SETUP: begin
        x_nxt      = x_src[MULT_BITS-1:0];
        addend_nxt = sq_r;
        acc_nxt    = '0;
        cnt_nxt    = CNT_W'(MULT_BITS);
      end
      mexp_pkg::ST_MUL: begin
        acc_nxt    = step_rsp.acc;
        addend_nxt = step_rsp.dbl;
        x_nxt      = x_r >> 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (last_step) begin
          if (!sel_r) begin
            res_nxt = step_rsp.acc;
            sel_nxt = 1'b1;
          end else begin
            sq_nxt  = step_rsp.acc;
            e_nxt   = e_shift;
            sel_nxt = ~e_shift[0];
          end
        end
      end
      mexp_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mexp_pkg::ST_IDLE;
      modulus_r <= mexp_pkg::MOD_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        modulus_r <= pwdata[OPW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    base_r   <= base_nxt;
    sq_r     <= sq_nxt;
    res_r    <= res_nxt;
    x_r      <= x_nxt;
    acc_r    <= acc_nxt;
    addend_r <= addend_nxt;
    cnt_r    <= cnt_nxt;
    sel_r    <= sel_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/mexp_checker.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the core's channels for its one-transaction-at-a-time behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire [mexp_pkg::OPW-1:0] power
);

  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("Core is ready for input while a result is pending.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Core is ready again right after accepting a transaction.");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (in_ready && !out_valid))
    else $error("Core did not return to idle after the result was taken.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(power)))
    else $error("Stalled result changed or was dropped.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("Core is not idle after reset.");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .power     (out_ch.power)
);

`default_nettype wire

@@ tb/sv/modular_exponentiation_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation core testbench
// Drives operand transactions through a directed table and then through
// random phases, each under its own modulus written over the APB port. Every
// result transaction is compared with a table value where given, or with a
// square-and-multiply model kept here, with both channels stalling at random.
// ----------------------------------------------------------------------------

module modular_exponentiation_core_tb;

  localparam int OPW         = mexp_pkg::OPW;
  localparam int IN_W        = mexp_pkg::IN_W;
  localparam int CFG_ADDR_W  = mexp_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = mexp_pkg::CFG_DATA_W;
  localparam int MULT_BITS   = mexp_pkg::MULT_BITS_DEF;
  localparam int REG_MODULUS = 0;
  localparam int PHASE_ITEMS = 38;
  localparam int NUM_PHASES  = 7;

  typedef struct {
    bit              set_mod;
    logic [OPW-1:0]  modulus;
    logic [IN_W-1:0] base;
    logic [IN_W-1:0] exponent;
    bit              known;
    logic [OPW-1:0]  power;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();

  logic [OPW-1:0] power_q[$];
  logic [OPW-1:0] modulus_cfg;
  bit             no_idle;
  int             mismatches;

  stim_row_t directed_rows [0:22] = '{
    '{1'b0, 31'd0,          32'h0000_0000, 32'h0000_0000, 1'b1, 31'd1},
    '{1'b0, 31'd0,          32'h0000_0005, 32'h0000_0000, 1'b1, 31'd1},
    '{1'b0, 31'd0,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 31'd1},
    '{1'b0, 31'd0,          32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 31'd0},
    '{1'b0, 31'd0,          32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 31'd0},
    '{1'b0, 31'd0,          32'h8000_0000, 32'h0000_3039, 1'b1, 31'd1},
    '{1'b0, 31'd0,          32'h0000_0002, 32'd30,        1'b1, 31'h4000_0000},
    '{1'b0, 31'd0,          32'h0000_0002, 32'd31,        1'b1, 31'd1},
    '{1'b0, 31'd0,          32'h7FFF_FFFE, 32'd2,         1'b1, 31'd1},
    '{1'b0, 31'd0,          32'h7FFF_FFFE, 32'd3,         1'b1, 31'h7FFF_FFFE},
    '{1'b0, 31'd0,          32'hDEAD_BEEF, 32'h8000_0001, 1'b0, 31'd0},
    '{1'b0, 31'd0,          32'h1234_5678, 32'hAAAA_AAAA, 1'b0, 31'd0},
    '{1'b1, 31'd1,          32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 31'd0},
    '{1'b0, 31'd0,          32'h0000_0007, 32'h0000_0005, 1'b1, 31'd0},
    '{1'b1, 31'd0,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 31'd0},
    '{1'b0, 31'd0,          32'h0000_0000, 32'h0000_0000, 1'b1, 31'd0},
    '{1'b1, 31'd2,          32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 31'd1},
    '{1'b0, 31'd0,          32'hFFFF_FFFE, 32'h0000_0007, 1'b1, 31'd0},
    '{1'b0, 31'd0,          32'h0000_0003, 32'hFFFF_FFFF, 1'b1, 31'd1},
    '{1'b1, 31'd1000000007, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 31'd0},
    '{1'b0, 31'd0,          32'h7FFF_FFFF, 32'd1000000005, 1'b0, 31'd0},
    '{1'b1, 31'h4000_0000,  32'h0000_0003, 32'hFFFF_FFFF, 1'b0, 31'd0},
    '{1'b0, 31'd0,          32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 31'd1}
  };

  modular_exponentiation_core #(
    .MULT_BITS(MULT_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bit [63:0] mul_mod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
    bit [63:0] acc;
    bit [63:0] addend;
    acc    = 0;
    x      = x % m;
    addend = y % m;
    for (int i = 0; i < MULT_BITS && i < OPW; i++) begin
      if (x[i]) begin
        acc = (acc + addend) % m;
      end
      addend = (addend * 2) % m;
    end
    return acc;
  endfunction

  function automatic logic [OPW-1:0] predict_power(logic [IN_W-1:0] b, logic [IN_W-1:0] e);
    bit [63:0] m;
    bit [63:0] result;
    bit [63:0] square;
    m = 64'(modulus_cfg);
    if (m == 0) begin
      return '0;
    end
    result = 1 % m;
    square = b % m;
    while (e != 0) begin
      if (e[0]) begin
        result = mul_mod(result, square, m);
      end
      square = mul_mod(square, square, m);
      e      = e >> 1;
    end
    return result[OPW-1:0];
  endfunction

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (power_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_modulus(input logic [OPW-1:0] m);
    logic [CFG_DATA_W-1:0] rd;
    drain_results();
    repeat (4) @(posedge clk);
    apb_access(1'b1, CFG_ADDR_W'(REG_MODULUS * 4), {1'b0, m}, rd);
    modulus_cfg = m;
    @(posedge clk);
    apb_access(1'b0, CFG_ADDR_W'(REG_MODULUS * 4), '0, rd);
    if (rd !== {1'b0, m}) begin
      $display("%0t: modulus readback mismatch, expected %0d, actual %0d",
               $time, {1'b0, m}, rd);
      mismatches++;
    end
  endtask

  task automatic send_operands(input logic [IN_W-1:0] b, input logic [IN_W-1:0] e,
                               input bit known, input logic [OPW-1:0] want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(18, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      while (gap > 0) begin
        @(posedge clk);
        if (power_q.size() == 0) begin
          gap--;
        end
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.base     <= b;
    in_ch.exponent <= e;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    power_q.push_back(known ? want : predict_power(b, e));
  endtask

  initial begin : power_sink
    int stall_left;
    logic [OPW-1:0] want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (power_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_ch.power);
          mismatches++;
        end else begin
          want = power_q.pop_front();
          if (out_ch.power !== want) begin
            $display("%0t: power mismatch, expected %0d, actual %0d",
                     $time, want, out_ch.power);
            mismatches++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(18, 0);
      end else if (out_ch.valid && stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= rst_n && (stall_left == 0);
    end
  end

  initial begin
    #80_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [OPW-1:0]  m;
    logic [IN_W-1:0] b;
    logic [IN_W-1:0] e;
    mismatches     = 0;
    no_idle        = 1'b0;
    modulus_cfg    = mexp_pkg::MOD_RESET;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.base     <= '0;
    in_ch.exponent <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_mod) begin
        set_modulus(directed_rows[i].modulus);
      end
      send_operands(directed_rows[i].base, directed_rows[i].exponent,
                    directed_rows[i].known, directed_rows[i].power);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: m = mexp_pkg::MOD_RESET;
        1: m = OPW'($urandom_range(32'h7FFF_FFFF, 2));
        2: m = OPW'($urandom_range(300, 2));
        3: m = OPW'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
        4: m = 31'd3;
        5: m = 31'd1;
        default: m = OPW'($urandom_range(32'h7FFF_FFFF, 2));
      endcase
      set_modulus(m);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        no_idle = (k >= 12 && k < 22);
        if (ph == 3 && k == 20) begin
          drain_results();
        end
        case ($urandom_range(9, 0))
          0:       b = {1'b0, m} - 1;
          1:       b = {1'b0, m};
          2:       b = {1'b0, m} + 1;
          3:       b = $urandom_range(255, 0);
          4:       b = {1'b0, m} * $urandom_range(2, 1);
          default: b = $urandom;
        endcase
        case ($urandom_range(7, 0))
          0:       e = $urandom_range(64, 0);
          1:       e = $urandom_range(7, 0);
          2:       e = 32'h1 << $urandom_range(31, 0);
          3:       e = 32'hFFFF_FFFF >> $urandom_range(31, 0);
          default: e = $urandom;
        endcase
        send_operands(b, e, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
